// ----- rtl/mbt_pkg.sv -----
// ----------------------------------------------------------------------------
// mbt_pkg
// Shared types and constants of the maze backtracker step block.
// ----------------------------------------------------------------------------
package mbt_pkg;

   localparam int CFG_W      = 7;   // width of a grid dimension register
   localparam int RANDOM_W   = 16;  // width of the random word
   localparam int COORD_W    = 6;   // width of the reported row and column
   localparam int EPOCH_W    = 4;   // width of a visited-map generation mark

   localparam logic [CFG_W-1:0] GRID_ROWS_RESET = 7'd10;
   localparam logic [CFG_W-1:0] GRID_COLS_RESET = 7'd30;

   // register indexes
   localparam logic CSR_GRID_ROWS = 1'b0;
   localparam logic CSR_GRID_COLS = 1'b1;

   // direction codes
   localparam logic [1:0] DIR_UP    = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

   typedef enum logic [2:0] {
      ST_WIPE,    // clearing pass over the visited map
      ST_IDLE,    // waiting for a request, reading up/down of the top cell
      ST_START,   // restart: mark (0,0), push it
      ST_TOPLD,   // load the new stack top after a pop
      ST_RDA,     // read up/down neighbours
      ST_RDB,     // read left/right neighbours
      ST_EVAL     // pick, carve, push or pop
   } state_type;

endpackage

// ----- rtl/maze_backtracker_step.sv -----
// ----------------------------------------------------------------------------
// maze_backtracker_step
// Randomised depth-first maze carver, one passage per request.
// ----------------------------------------------------------------------------
// A request carries a restart flag and a 16-bit random word; every request
// returns exactly one response: the carved edge (from cell and direction), a
// goal flag when the edge enters the bottom-right cell, or done when the
// stack has run empty. The visited map and the path stack each live in a
// synchronous RAM of MAX_ROWS x MAX_COLS entries (rounded up to powers of
// two), so timing is set by their registered reads and the two read ports of
// the visited map. A plain request reads up/down, reads left/right, then
// evaluates and writes back; a restart first marks and pushes (0,0); each cell
// popped while backtracking reloads the stack top before the reads repeat, and
// the final pop that empties the stack adds an evaluate step. Visited entries
// hold a 4-bit generation mark instead of a bit, so a restart normally clears
// the map at once; every 15th restart, and once after reset, the block instead
// runs a clearing pass over 2**(RW + CW) cells, RW and CW being the row and
// column address widths of at least 1 bit each (4096 at the defaults), during
// which no request is taken. Grid dimensions may be written only while the
// block is idle; values outside 1..MAX are saturated. A finished response
// sits in an output register, so the next request is taken while it waits.
module maze_backtracker_step
   import mbt_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CFG_W-1:0]    csr_wdata,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_restart,
   input  logic [RANDOM_W-1:0] req_random_word,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_carved,
   output logic [COORD_W-1:0]  rsp_from_row,
   output logic [COORD_W-1:0]  rsp_from_col,
   output logic [1:0]          rsp_direction,
   output logic                rsp_reached_goal,
   output logic                rsp_done_res
);

   localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AW        = RW + CW;
   localparam int DW        = AW + 1;
   localparam int MEM_DEPTH = 1 << AW;
   localparam int CELLS     = MAX_ROWS * MAX_COLS;
   localparam int DRW       = $clog2(MAX_ROWS + 1);
   localparam int DCW       = $clog2(MAX_COLS + 1);

   // random word mod 3: base-4 digit sum, then a small fold
   function automatic logic [1:0] mod3_16(input logic [RANDOM_W-1:0] v);
      logic [4:0] s;
      logic [2:0] t;
      s = '0;
      for (int i = 0; i < RANDOM_W / 2; i++) begin
         s = s + 5'(v[2*i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      if (t >= 3'd6) begin
         t = t - 3'd6;
      end else if (t >= 3'd3) begin
         t = t - 3'd3;
      end
      return t[1:0];
   endfunction

   // ---------------------------------------------------------------- state
   state_type             state_ff, state_in;
   logic [CFG_W-1:0]      grid_rows_ff, grid_cols_ff;
   logic [EPOCH_W-1:0]    epoch_ff, epoch_in;
   logic [AW-1:0]         wipe_ff, wipe_in;
   logic                  restart_pend_ff, restart_pend_in;
   logic [DW-1:0]         depth_ff, depth_in;
   logic [AW-1:0]         top_cell_ff, top_cell_in;
   logic [1:0]            free_ud_ff, free_ud_in;
   logic [1:0]            rnd_lo_ff;
   logic [1:0]            rnd_mod3_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_carved_ff, rsp_carved_in;
   logic [COORD_W-1:0]    rsp_from_row_ff, rsp_from_row_in;
   logic [COORD_W-1:0]    rsp_from_col_ff, rsp_from_col_in;
   logic [1:0]            rsp_direction_ff, rsp_direction_in;
   logic                  rsp_reached_goal_ff, rsp_reached_goal_in;
   logic                  rsp_done_res_ff, rsp_done_res_in;

   // memories
   logic [EPOCH_W-1:0]    visited_mem [0:MEM_DEPTH-1];
   logic [AW-1:0]         stack_mem   [0:MEM_DEPTH-1];
   logic [EPOCH_W-1:0]    vis_qa_ff, vis_qb_ff;
   logic [AW-1:0]         stack_q_ff;

   logic                  vis_we;
   logic [AW-1:0]         vis_waddr;
   logic [EPOCH_W-1:0]    vis_wdata;
   logic [AW-1:0]         vis_raddr_a, vis_raddr_b;
   logic                  stk_we;
   logic [AW-1:0]         stk_waddr, stk_wdata, stk_raddr;

   // ---------------------------------------------------------------- grid
   logic [DRW-1:0]        rows_eff;
   logic [DCW-1:0]        cols_eff;
   logic [RW-1:0]         top_r;
   logic [CW-1:0]         top_c;
   logic                  up_ok, dn_ok, lf_ok, rt_ok;
   logic [AW-1:0]         up_addr, dn_addr, lf_addr, rt_addr;

   logic                  req_fire, out_free;
   logic [3:0]            free_all;
   logic [2:0]            free_cnt;
   logic [1:0]            sel;
   logic [1:0]            pick_dir;
   logic [RW-1:0]         new_r;
   logic [CW-1:0]         new_c;
   logic                  goal_hit;
   logic                  ev_empty, ev_pop, ev_carve, ev_emit;

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (grid_rows_ff == '0) begin
         rows_eff = DRW'(1);
      end else if (32'(grid_rows_ff) > 32'(MAX_ROWS)) begin
         rows_eff = DRW'(MAX_ROWS);
      end else begin
         rows_eff = DRW'(grid_rows_ff);
      end
      if (grid_cols_ff == '0) begin
         cols_eff = DCW'(1);
      end else if (32'(grid_cols_ff) > 32'(MAX_COLS)) begin
         cols_eff = DCW'(MAX_COLS);
      end else begin
         cols_eff = DCW'(grid_cols_ff);
      end
   end

   assign top_r = top_cell_ff[AW-1:CW];
   assign top_c = top_cell_ff[CW-1:0];

   // in-grid tests per neighbour; stacked cells may lie outside a shrunk grid
   assign up_ok = (top_r != '0) && (32'(top_r) - 32'd1 < 32'(rows_eff))
                  && (32'(top_c) < 32'(cols_eff));
   assign dn_ok = (32'(top_r) + 32'd1 < 32'(rows_eff)) && (32'(top_c) < 32'(cols_eff));
   assign lf_ok = (top_c != '0) && (32'(top_c) - 32'd1 < 32'(cols_eff))
                  && (32'(top_r) < 32'(rows_eff));
   assign rt_ok = (32'(top_c) + 32'd1 < 32'(cols_eff)) && (32'(top_r) < 32'(rows_eff));

   assign up_addr = {RW'(top_r - RW'(1)), top_c};
   assign dn_addr = {RW'(top_r + RW'(1)), top_c};
   assign lf_addr = {top_r, CW'(top_c - CW'(1))};
   assign rt_addr = {top_r, CW'(top_c + CW'(1))};

   // up/down results captured in ST_RDB; left/right come straight off the RAM
   assign free_ud_in = {dn_ok && (vis_qb_ff != epoch_ff), up_ok && (vis_qa_ff != epoch_ff)};
   assign free_all   = {rt_ok && (vis_qb_ff != epoch_ff), lf_ok && (vis_qa_ff != epoch_ff),
                        free_ud_ff};
   assign free_cnt   = 3'(free_all[0]) + 3'(free_all[1]) + 3'(free_all[2]) + 3'(free_all[3]);

   // random word mod candidate count
   always_comb begin
      case (free_cnt)
         3'd2:    sel = {1'b0, rnd_lo_ff[0]};
         3'd3:    sel = rnd_mod3_ff;
         3'd4:    sel = rnd_lo_ff;
         default: sel = 2'd0;
      endcase
   end

   // sel-th free neighbour in list order
   always_comb begin
      logic [1:0] cnt;
      logic       found;
      cnt      = '0;
      found    = 1'b0;
      pick_dir = DIR_UP;
      for (int i = 0; i < 4; i++) begin
         if (free_all[i] && !found) begin
            if (cnt == sel) begin
               pick_dir = 2'(i);
               found    = 1'b1;
            end
            cnt = cnt + 2'd1;
         end
      end
   end

   always_comb begin
      new_r = top_r;
      new_c = top_c;
      case (pick_dir)
         DIR_UP:    new_r = RW'(top_r - RW'(1));
         DIR_DOWN:  new_r = RW'(top_r + RW'(1));
         DIR_LEFT:  new_c = CW'(top_c - CW'(1));
         DIR_RIGHT: new_c = CW'(top_c + CW'(1));
         default:   new_r = top_r;
      endcase
   end

   assign goal_hit = (32'(new_r) + 32'd1 == 32'(rows_eff))
                     && (32'(new_c) + 32'd1 == 32'(cols_eff));

   // evaluate decode
   assign ev_empty = (depth_ff == '0);
   assign ev_pop   = !ev_empty && (free_cnt == 3'd0);
   assign ev_carve = !ev_empty && (free_cnt != 3'd0) && out_free;
   assign ev_emit  = (ev_empty && out_free) || ev_carve;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_WIPE: begin
            if (&wipe_ff) begin
               state_in = restart_pend_ff ? ST_START : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (!req_restart) begin
                  state_in = ST_RDB;
               end else if (epoch_ff == EPOCH_LAST) begin
                  state_in = ST_WIPE;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: state_in = ST_RDA;
         ST_TOPLD: state_in = ST_RDA;
         ST_RDA:   state_in = ST_RDB;
         ST_RDB:   state_in = ST_EVAL;
         ST_EVAL: begin
            if (ev_emit) begin
               state_in = ST_IDLE;
            end else if (ev_pop && depth_ff != DW'(1)) begin
               state_in = ST_TOPLD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      epoch_in        = epoch_ff;
      wipe_in         = wipe_ff;
      restart_pend_in = restart_pend_ff;
      depth_in        = depth_ff;
      top_cell_in     = top_cell_ff;

      vis_we      = 1'b0;
      vis_waddr   = top_cell_ff;
      vis_wdata   = epoch_ff;
      vis_raddr_a = up_addr;
      vis_raddr_b = dn_addr;
      stk_we      = 1'b0;
      stk_waddr   = depth_ff[AW-1:0];
      stk_wdata   = top_cell_ff;
      stk_raddr   = AW'(depth_ff - DW'(2));

      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_carved_in       = rsp_carved_ff;
      rsp_from_row_in     = rsp_from_row_ff;
      rsp_from_col_in     = rsp_from_col_ff;
      rsp_direction_in    = rsp_direction_ff;
      rsp_reached_goal_in = rsp_reached_goal_ff;
      rsp_done_res_in     = rsp_done_res_ff;

      req_ready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_WIPE: begin
            vis_we    = 1'b1;
            vis_waddr = wipe_ff;
            vis_wdata = EPOCH_CLEAR;
            wipe_in   = AW'(wipe_ff + AW'(1));
            if (&wipe_ff) begin
               restart_pend_in = 1'b0;
               epoch_in        = EPOCH_FIRST;
            end
         end
         ST_IDLE: begin
            if (req_fire && req_restart) begin
               if (epoch_ff == EPOCH_LAST) begin
                  wipe_in         = '0;
                  restart_pend_in = 1'b1;
               end else begin
                  epoch_in = EPOCH_W'(epoch_ff + EPOCH_W'(1));
               end
            end
         end
         ST_START: begin
            vis_we      = 1'b1;
            vis_waddr   = '0;
            stk_we      = 1'b1;
            stk_waddr   = '0;
            stk_wdata   = '0;
            depth_in    = DW'(1);
            top_cell_in = '0;
         end
         ST_TOPLD: begin
            top_cell_in = stack_q_ff;
         end
         ST_RDA: begin
            vis_raddr_a = up_addr;
            vis_raddr_b = dn_addr;
         end
         ST_RDB, ST_EVAL: begin
            // hold left/right reads so the RAM outputs stay put while stalled
            vis_raddr_a = lf_addr;
            vis_raddr_b = rt_addr;
            if (state_ff == ST_EVAL) begin
               if (ev_pop) begin
                  depth_in = DW'(depth_ff - DW'(1));
               end
               if (ev_carve) begin
                  vis_we      = 1'b1;
                  vis_waddr   = {new_r, new_c};
                  top_cell_in = {new_r, new_c};
                  if (32'(depth_ff) < CELLS) begin
                     stk_we    = 1'b1;
                     stk_wdata = {new_r, new_c};
                     depth_in  = DW'(depth_ff + DW'(1));
                  end
               end
               if (ev_emit) begin
                  rsp_valid_in        = 1'b1;
                  rsp_carved_in       = ev_carve;
                  rsp_from_row_in     = ev_carve ? COORD_W'(top_r) : '0;
                  rsp_from_col_in     = ev_carve ? COORD_W'(top_c) : '0;
                  rsp_direction_in    = ev_carve ? pick_dir : DIR_UP;
                  rsp_reached_goal_in = ev_carve && goal_hit;
                  rsp_done_res_in     = !ev_carve;
               end
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_WIPE;
         grid_rows_ff    <= GRID_ROWS_RESET;
         grid_cols_ff    <= GRID_COLS_RESET;
         epoch_ff        <= EPOCH_FIRST;
         wipe_ff         <= '0;
         restart_pend_ff <= 1'b0;
         depth_ff        <= '0;
         top_cell_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         epoch_ff        <= epoch_in;
         wipe_ff         <= wipe_in;
         restart_pend_ff <= restart_pend_in;
         depth_ff        <= depth_in;
         top_cell_ff     <= top_cell_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_ROWS: grid_rows_ff <= csr_wdata;
               CSR_GRID_COLS: grid_cols_ff <= csr_wdata;
               default:       grid_rows_ff <= grid_rows_ff;
            endcase
         end
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_RDB) begin
         free_ud_ff <= free_ud_in;
      end
      if (req_fire) begin
         rnd_lo_ff   <= req_random_word[1:0];
         rnd_mod3_ff <= mod3_16(req_random_word);
      end
      rsp_carved_ff       <= rsp_carved_in;
      rsp_from_row_ff     <= rsp_from_row_in;
      rsp_from_col_ff     <= rsp_from_col_in;
      rsp_direction_ff    <= rsp_direction_in;
      rsp_reached_goal_ff <= rsp_reached_goal_in;
      rsp_done_res_ff     <= rsp_done_res_in;
   end

   // visited map: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (vis_we) begin
         visited_mem[vis_waddr] <= vis_wdata;
      end
      vis_qa_ff <= visited_mem[vis_raddr_a];
      vis_qb_ff <= visited_mem[vis_raddr_b];
   end

   // path stack: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      stack_q_ff <= stack_mem[stk_raddr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_carved       = rsp_carved_ff;
   assign rsp_from_row     = rsp_from_row_ff;
   assign rsp_from_col     = rsp_from_col_ff;
   assign rsp_direction    = rsp_direction_ff;
   assign rsp_reached_goal = rsp_reached_goal_ff;
   assign rsp_done_res     = rsp_done_res_ff;

endmodule

// ----- test/maze_backtracker_step_tb.sv -----
// ----------------------------------------------------------------------------
// maze_backtracker_step_tb
// Self-checking regression for the maze backtracker step block.
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the visited map, the path stack
// and the grid registers. For every accepted request it carves the same
// passage the block should carve and queues the expected response; every
// accepted response is checked field by field against the oldest entry.
// A directed opening covers requests before any restart, one-cell grids,
// saturated dimensions, the goal cell and a grid shrunk and grown mid-maze.
// Random mazes follow, mostly small grids carved to completion, with random
// idling on both channels and the odd restart thrown in mid-maze.
// ----------------------------------------------------------------------------
module maze_backtracker_step_tb;
   import mbt_pkg::*;

   localparam int MAX_ROWS      = 64;
   localparam int MAX_COLS      = 64;
   localparam int CELLS         = MAX_ROWS * MAX_COLS;
   localparam int ITEM_TARGET   = 1200;
   // Slowest correct run: ~1300 requests, each with the longest sender gap,
   // the longest receiver stall and the block's own steps, pops bounded by
   // carves, plus a clearing pass after reset and on every 15th restart.
   // The limit lies well above that total.
   localparam int LIMIT_CYCLES  = 800_000;

   typedef struct packed {
      logic                carved;
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      logic [1:0]          dir;
      logic                goal;
      logic                done;
   } maze_resp_type;

   // -------------------------------------------------------------------------
   // Scoreboard: maze carver of its own plus the queue of awaited responses
   // -------------------------------------------------------------------------
   class maze_scoreboard;
      bit               visited [CELLS];
      logic [11:0]      path [CELLS];
      int unsigned      depth;
      logic [CFG_W-1:0] rows_reg;
      logic [CFG_W-1:0] cols_reg;
      maze_resp_type    awaited_q [$];
      int unsigned      errors, requests, restarts, carves, goals, dones;

      function new();
         rows_reg = GRID_ROWS_RESET;
         cols_reg = GRID_COLS_RESET;
         depth    = 0;
         foreach (visited[i]) visited[i] = 1'b0;
      endfunction

      static function int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
         if (v == 0) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      function void write_dim(logic idx, logic [CFG_W-1:0] v);
         if (idx == CSR_GRID_ROWS) rows_reg = v;
         else cols_reg = v;
      endfunction

      function bit is_free(int unsigned r, int unsigned c);
         return !visited[r * MAX_COLS + c];
      endfunction

      // carve one passage for an accepted request, queue what should come back
      function void note_request(logic restart, logic [RANDOM_W-1:0] word);
         int unsigned   rows, cols, r, c, nr, nc, n, top;
         logic [1:0]    cand [4];
         logic [1:0]    d;
         maze_resp_type e;
         rows = clamp_dim(rows_reg, MAX_ROWS);
         cols = clamp_dim(cols_reg, MAX_COLS);
         requests++;
         if (restart) begin
            foreach (visited[i]) visited[i] = 1'b0;
            visited[0] = 1'b1;
            path[0]    = '0;
            depth      = 1;
            restarts++;
         end
         n = 0;
         r = 0;
         c = 0;
         // backtrack until the top cell has a free neighbour
         while (depth > 0) begin
            top = path[depth-1];
            r   = top / MAX_COLS;
            c   = top % MAX_COLS;
            n   = 0;
            if (r > 0 && r - 1 < rows && c < cols && is_free(r - 1, c)) begin
               cand[n] = DIR_UP;
               n++;
            end
            if (r + 1 < rows && c < cols && is_free(r + 1, c)) begin
               cand[n] = DIR_DOWN;
               n++;
            end
            if (c > 0 && c - 1 < cols && r < rows && is_free(r, c - 1)) begin
               cand[n] = DIR_LEFT;
               n++;
            end
            if (c + 1 < cols && r < rows && is_free(r, c + 1)) begin
               cand[n] = DIR_RIGHT;
               n++;
            end
            if (n > 0) break;
            depth--;
         end
         e = '0;
         if (n == 0) begin
            e.done = 1'b1;
            dones++;
         end else begin
            d  = cand[word % n];
            nr = r;
            nc = c;
            case (d)
               DIR_UP:   nr = r - 1;
               DIR_DOWN: nr = r + 1;
               DIR_LEFT: nc = c - 1;
               default:  nc = c + 1;
            endcase
            visited[nr * MAX_COLS + nc] = 1'b1;
            path[depth] = 12'(nr * MAX_COLS + nc);
            depth++;
            e.carved = 1'b1;
            e.row    = r[COORD_W-1:0];
            e.col    = c[COORD_W-1:0];
            e.dir    = d;
            e.goal   = (nr + 1 == rows && nc + 1 == cols);
            carves++;
            if (e.goal) goals++;
         end
         awaited_q.insert(awaited_q.size(), e);
      endfunction

      task report(string what, int unsigned want, int unsigned got);
         errors++;
         if (errors <= 40)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      endtask

      task check_response(maze_resp_type got);
         maze_resp_type want;
         if (awaited_q.size() == 0) begin
            report("response with no request outstanding", 0, 1);
            return;
         end
         want = awaited_q.pop_front();
         if (got.carved !== want.carved) report("carved", want.carved, got.carved);
         if (got.row    !== want.row)    report("from_row", want.row, got.row);
         if (got.col    !== want.col)    report("from_col", want.col, got.col);
         if (got.dir    !== want.dir)    report("direction", want.dir, got.dir);
         if (got.goal   !== want.goal)   report("reached_goal", want.goal, got.goal);
         if (got.done   !== want.done)   report("done_res", want.done, got.done);
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block under test
   // -------------------------------------------------------------------------
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic                csr_index = CSR_GRID_ROWS;
   logic [CFG_W-1:0]    csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_restart = 1'b0;
   logic [RANDOM_W-1:0] req_random_word = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_carved;
   logic [COORD_W-1:0]  rsp_from_row;
   logic [COORD_W-1:0]  rsp_from_col;
   logic [1:0]          rsp_direction;
   logic                rsp_reached_goal;
   logic                rsp_done_res;

   maze_scoreboard      sb = new();
   bit                  quiet = 1'b0;   // phase with no idling on either side
   int unsigned         cycles = 0;
   int unsigned         phases = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   maze_backtracker_step #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart      (req_restart),
      .req_random_word  (req_random_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_carved       (rsp_carved),
      .rsp_from_row     (rsp_from_row),
      .rsp_from_col     (rsp_from_col),
      .rsp_direction    (rsp_direction),
      .rsp_reached_goal (rsp_reached_goal),
      .rsp_done_res     (rsp_done_res)
   );

   // -------------------------------------------------------------------------
   // Idling: mostly back-to-back or short gaps, now and then a long one
   // -------------------------------------------------------------------------
   function automatic int unsigned gap_len();
      int unsigned p;
      if (quiet) return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver: stall, then a burst of ready cycles; one drive per falling edge
   initial begin
      int unsigned stall;
      forever begin
         stall = gap_len();
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         repeat ($urandom_range(1, 6)) begin
            @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // responses are taken at the rising edge where valid and ready meet
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(maze_resp_type'{rsp_carved, rsp_from_row, rsp_from_col,
                                           rsp_direction, rsp_reached_goal,
                                           rsp_done_res});
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("[%0t] timeout with %0d responses outstanding", $time,
                  sb.awaited_q.size());
         $display("maze_backtracker_step regression: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   // Offer one request after a random gap; valid holds until it is taken.
   task automatic send_request(logic restart, logic [RANDOM_W-1:0] word);
      int unsigned gap;
      gap = gap_len();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_restart     <= restart;
      req_random_word <= word;
      do @(posedge clock); while (!req_ready);
      sb.note_request(restart, word);
   endtask

   // Hold off new requests until every response is back, then settle.
   task automatic drain(int unsigned settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.awaited_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.write_dim(idx, value);
   endtask

   // grid registers only change with the block idle
   task automatic set_grid(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
      drain(8);
      write_csr(CSR_GRID_ROWS, rows);
      write_csr(CSR_GRID_COLS, cols);
   endtask

   function automatic logic [RANDOM_W-1:0] pick_word();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 3) return '0;
      if (p < 6) return '1;
      return RANDOM_W'($urandom);
   endfunction

   // A run of requests on the current grid; the first may restart the maze.
   // A stray restart or a full pause now and then shakes things up.
   task automatic run_maze(int unsigned count, bit fresh);
      logic restart;
      for (int unsigned i = 0; i < count; i++) begin
         restart = (i == 0 && fresh) || ($urandom_range(0, 99) < 2);
         if ($urandom_range(0, 99) == 0) drain(0);
         send_request(restart, pick_word());
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int unsigned p, cells, count;
      logic [CFG_W-1:0] rows_v, cols_v;
      logic [CFG_W-1:0] extremes [6];

      extremes = '{7'd0, 7'd1, 7'd63, 7'd64, 7'd65, 7'd127};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no restart yet: empty stack, every request answers done
      send_request(1'b0, 16'h0000);
      send_request(1'b0, 16'hFFFF);
      send_request(1'b0, 16'h1234);
      // first maze on the reset grid of 10 x 30
      send_request(1'b1, 16'h0000);
      send_request(1'b0, 16'hFFFF);
      send_request(1'b0, 16'hAAAA);
      send_request(1'b0, 16'h5555);
      // one-cell grid: nothing to carve at all
      set_grid(7'd1, 7'd1);
      run_maze(2, 1'b1);
      // zero dimensions saturate to one
      set_grid(7'd0, 7'd0);
      run_maze(1, 1'b1);
      // one row of two: the only passage enters the goal, then done
      set_grid(7'd1, 7'd2);
      run_maze(2, 1'b1);
      set_grid(7'd2, 7'd1);
      run_maze(1, 1'b1);
      // oversized registers saturate to the full grid
      set_grid(7'd127, 7'd127);
      run_maze(3, 1'b1);
      // shrink the grid under a maze in progress, then grow it again
      set_grid(7'd4, 7'd4);
      run_maze(5, 1'b1);
      set_grid(7'd2, 7'd2);
      run_maze(3, 1'b0);
      set_grid(7'd64, 7'd64);
      run_maze(2, 1'b0);

      // random mazes, mostly small grids carved right through to done
      while (sb.requests < ITEM_TARGET) begin
         drain(8);
         quiet = ($urandom_range(0, 4) == 0);
         p = $urandom_range(0, 99);
         if (p < 70) begin
            rows_v = CFG_W'($urandom_range(1, 8));
            cols_v = CFG_W'($urandom_range(1, 8));
         end else if (p < 85) begin
            rows_v = CFG_W'($urandom_range(1, 16));
            cols_v = CFG_W'($urandom_range(1, 16));
         end else if (p < 93) begin
            rows_v = extremes[$urandom_range(0, 5)];
            cols_v = extremes[$urandom_range(0, 5)];
         end else begin
            rows_v = CFG_W'($urandom_range(0, 127));
            cols_v = CFG_W'($urandom_range(0, 127));
         end
         write_csr(CSR_GRID_ROWS, rows_v);
         if ($urandom_range(0, 6) != 0) write_csr(CSR_GRID_COLS, cols_v);
         cells = maze_scoreboard::clamp_dim(sb.rows_reg, MAX_ROWS)
               * maze_scoreboard::clamp_dim(sb.cols_reg, MAX_COLS);
         count = cells + $urandom_range(0, 3);
         if (count > 80) count = 80;
         run_maze(count, $urandom_range(0, 9) != 0);
         phases++;
      end

      quiet = 1'b0;
      drain(20);
      $display("covered %0d requests (%0d restarts) over %0d random grid settings",
               sb.requests, sb.restarts, phases);
      $display("responses: %0d passages carved, %0d into the goal, %0d done; %0d mismatches",
               sb.carves, sb.goals, sb.dones, sb.errors);
      if (sb.errors == 0)
         $display("maze_backtracker_step regression: pass");
      else
         $display("maze_backtracker_step regression: fail");
      $finish;
   end

endmodule

// ----- maze_backtracker_step.f -----
rtl/mbt_pkg.sv
rtl/maze_backtracker_step.sv
test/maze_backtracker_step_tb.sv
